// ===== design/nfia_pkg.sv =====
`default_nettype none

package nfia_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_t;

endpackage

`default_nettype wire

// ===== design/nfia_ffz.sv =====
`default_nettype none

module nfia_ffz (
  input  nfia_pkg::word_t used,
  output nfia_pkg::ffz_t  hit
);

  // lowest clear bit of one bitmap word
  always_comb begin
    hit.found = 1'b0;
    hit.pos   = '0;
    for (int i = nfia_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!used[i]) begin
        hit.found = 1'b1;
        hit.pos   = nfia_pkg::BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/next_fit_id_allocator.sv =====
// Next-fit identifier allocator.
// Command channel: start with op and release_index is taken when busy is low.
// op 0 allocates the first free identifier at or after the search pointer,
// wrapping to zero; op 1 frees release_index. Every command yields exactly one
// result: done pulses for one cycle with granted_index, ok and live_count.
// The bitmap lives in a memory of 32-bit words with one registered read port;
// a single find-first-zero unit inspects one word per visit, and each visit
// reads the word, then tests it and writes it back.
// An allocate visits k words, 1 <= k <= ceil(POOL_SIZE/32)+1; a free of an
// identifier inside the pool reads its word, then tests the bit and clears it
// if set; an allocate on a full pool or a free beyond the pool answers
// straight from idle without a read. busy is high for the whole search, and
// a new command may be accepted in the cycle that carries the strobe.
// Reset clears the pointer, the count and a per-word valid bit, so every word
// reads as free right after reset with no clearing pass. The receiver cannot
// stall: each result is shown for one cycle only.
`default_nettype none

module next_fit_id_allocator #(
  parameter int POOL_SIZE = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       op,
  input  wire logic [7:0] release_index,
  output logic            done,
  output logic [7:0]      granted_index,
  output logic            ok,
  output logic [8:0]      live_count
);

  localparam int WORD_W    = nfia_pkg::WORD_W;
  localparam int BIT_W     = nfia_pkg::BIT_W;
  localparam int NWORDS    = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int FULL_W    = WADDR_W + BIT_W;
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int LAST_BITS = POOL_SIZE - (NWORDS - 1) * WORD_W;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);
  localparam nfia_pkg::word_t TAIL_MASK =
    ~((nfia_pkg::word_t'(1) << LAST_BITS) - nfia_pkg::word_t'(1));

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ARD  = 3'd1;
  localparam logic [2:0] ST_ACHK = 3'd2;
  localparam logic [2:0] ST_FRD  = 3'd3;
  localparam logic [2:0] ST_FCHK = 3'd4;

  logic [2:0]         state;
  logic [WADDR_W-1:0] cur_word;
  logic               first;
  logic [BIT_W-1:0]   rel_bit;
  logic [FULL_W-1:0]  ptr;
  logic [CNT_W-1:0]   count;
  logic [NWORDS-1:0]  word_valid;

  nfia_pkg::word_t mem [NWORDS];
  nfia_pkg::word_t rd_q;
  logic            rd_v_q;

  nfia_pkg::word_t raw;
  nfia_pkg::word_t low_mask;
  nfia_pkg::word_t scan;
  nfia_pkg::ffz_t  hit;
  logic [FULL_W-1:0] slot;
  logic [FULL_W:0]   slot_inc;
  logic [FULL_W-1:0] rel_full;
  logic              accept;
  logic              in_pool;
  logic              full;
  logic [CNT_W-1:0]  count_up;
  logic [CNT_W-1:0]  count_dn;
  logic [WADDR_W-1:0] word_inc;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign rel_full = FULL_W'(release_index);
  assign in_pool  = 32'(release_index) < POOL_SIZE;
  assign full     = (count == CNT_W'(POOL_SIZE));
  assign count_up = count + CNT_W'(1);
  assign count_dn = count - CNT_W'(1);
  assign word_inc = (cur_word == LAST_WORD) ? '0 : cur_word + WADDR_W'(1);

  assign raw      = rd_v_q ? rd_q : '0;
  assign low_mask = first ? ((nfia_pkg::word_t'(1) << ptr[BIT_W-1:0]) - nfia_pkg::word_t'(1))
                          : '0;
  assign scan     = raw | low_mask | ((cur_word == LAST_WORD) ? TAIL_MASK : '0);
  assign slot     = {cur_word, hit.pos};
  assign slot_inc = {1'b0, slot} + (FULL_W+1)'(1);

  nfia_ffz u_ffz (
    .used (scan),
    .hit  (hit)
  );

  // bitmap word read
  always_ff @(posedge clk) begin
    rd_q   <= mem[cur_word];
    rd_v_q <= word_valid[cur_word];
  end

  // bitmap word write back
  always_ff @(posedge clk) begin
    if (state == ST_ACHK && hit.found) begin
      mem[cur_word] <= raw | (nfia_pkg::word_t'(1) << hit.pos);
    end else if (state == ST_FCHK && raw[rel_bit]) begin
      mem[cur_word] <= raw & ~(nfia_pkg::word_t'(1) << rel_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ptr        <= '0;
      count      <= '0;
      word_valid <= '0;
      done       <= 1'b0;
      first      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!op) begin
              if (full) begin
                done          <= 1'b1;
                granted_index <= 8'(POOL_SIZE - 1);
                ok            <= 1'b0;
                live_count    <= 9'(count);
              end else begin
                cur_word <= ptr[FULL_W-1:BIT_W];
                first    <= 1'b1;
                state    <= ST_ARD;
              end
            end else begin
              if (in_pool) begin
                cur_word <= rel_full[FULL_W-1:BIT_W];
                rel_bit  <= release_index[BIT_W-1:0];
                state    <= ST_FRD;
              end else begin
                done          <= 1'b1;
                granted_index <= release_index;
                ok            <= 1'b0;
                live_count    <= 9'(count);
              end
            end
          end
        end
        ST_ARD: begin
          state <= ST_ACHK;
        end
        ST_ACHK: begin
          if (hit.found) begin
            word_valid[cur_word] <= 1'b1;
            count         <= count_up;
            ptr           <= (slot_inc == (FULL_W+1)'(POOL_SIZE)) ? '0
                                                                 : slot_inc[FULL_W-1:0];
            done          <= 1'b1;
            granted_index <= 8'(slot);
            ok            <= 1'b1;
            live_count    <= 9'(count_up);
            state         <= ST_IDLE;
          end else begin
            cur_word <= word_inc;
            first    <= 1'b0;
            state    <= ST_ARD;
          end
        end
        ST_FRD: begin
          state <= ST_FCHK;
        end
        ST_FCHK: begin
          done          <= 1'b1;
          granted_index <= 8'({cur_word, rel_bit});
          if (raw[rel_bit]) begin
            count      <= count_dn;
            ok         <= 1'b1;
            live_count <= 9'(count_dn);
          end else begin
            ok         <= 1'b0;
            live_count <= 9'(count);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/nfia_chk.sv =====
`default_nettype none

module nfia_chk #(
  parameter int POOL_SIZE = 256
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       op,
  input wire logic [7:0] release_index,
  input wire logic       done,
  input wire logic [7:0] granted_index,
  input wire logic       ok,
  input wire logic [8:0] live_count
);

  // every accepted command either starts a search or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor answered");

  // busy only rises after a transfer on the command side
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // results come out only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a rejected command right after another result leaves the live count as it was
  a_reject_count: assert property (@(posedge clk) disable iff (rst)
    (done && !ok && $past(done) && !$past(rst)) |-> (live_count == $past(live_count)))
    else $error("rejected command changed the count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(live_count) <= POOL_SIZE))
    else $error("live count beyond pool size");

endmodule

bind next_fit_id_allocator nfia_chk #(.POOL_SIZE(POOL_SIZE)) u_nfia_chk (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .op            (op),
  .release_index (release_index),
  .done          (done),
  .granted_index (granted_index),
  .ok            (ok),
  .live_count    (live_count)
);

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;

  localparam int POOL           = 256;
  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_ITEMS   = 400;
  localparam int MAX_SHOWN      = 20;
  localparam int NUM_DIRECTED   = 15;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [7:0] index;
    logic       ok;
    logic [8:0] count;
  } grant_t;

  typedef struct packed {
    logic       op;
    logic [7:0] index;
    logic       typed;
    grant_t     want;
  } cmd_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       op = OP_ALLOC;
  logic [7:0] release_index = 8'd0;
  logic       done;
  logic [7:0] granted_index;
  logic       ok;
  logic [8:0] live_count;

  logic   row_typed = 1'b0;
  grant_t row_want = '0;

  bit [POOL-1:0] id_used;
  bit [8:0]      next_ptr;
  bit [8:0]      held_ids;

  grant_t pending_grants[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     n_granted = 0;
  int     n_refused = 0;
  int     n_freed = 0;
  int     n_bad_free = 0;

  // typed rows hold values that follow straight from the allocation rules
  cmd_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_FREE,  8'd0,   1'b1, {8'd0,   1'b0, 9'd0}},
    '{OP_FREE,  8'd255, 1'b1, {8'd255, 1'b0, 9'd0}},
    '{OP_FREE,  8'd128, 1'b1, {8'd128, 1'b0, 9'd0}},
    '{OP_ALLOC, 8'd255, 1'b1, {8'd0,   1'b1, 9'd1}},
    '{OP_ALLOC, 8'd0,   1'b1, {8'd1,   1'b1, 9'd2}},
    '{OP_ALLOC, 8'd170, 1'b1, {8'd2,   1'b1, 9'd3}},
    '{OP_FREE,  8'd1,   1'b1, {8'd1,   1'b1, 9'd2}},
    '{OP_FREE,  8'd1,   1'b1, {8'd1,   1'b0, 9'd2}},
    '{OP_ALLOC, 8'd85,  1'b1, {8'd3,   1'b1, 9'd3}},
    '{OP_ALLOC, 8'd0,   1'b0, 18'd0},
    '{OP_FREE,  8'd0,   1'b0, 18'd0},
    '{OP_ALLOC, 8'd255, 1'b0, 18'd0},
    '{OP_FREE,  8'd170, 1'b0, 18'd0},
    '{OP_FREE,  8'd85,  1'b0, 18'd0},
    '{OP_ALLOC, 8'd0,   1'b0, 18'd0}
  };

  next_fit_id_allocator #(
    .POOL_SIZE(POOL)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .release_index(release_index),
    .done(done),
    .granted_index(granted_index),
    .ok(ok),
    .live_count(live_count)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic grant_t compute_grant(input logic cmd_op, input logic [7:0] rel);
    grant_t g;
    int     slot;
    int     i;
    g = '0;
    slot = -1;
    if (cmd_op == OP_ALLOC) begin
      if (held_ids < POOL) begin
        for (i = next_ptr; i < POOL && slot < 0; i++) begin
          if (!id_used[i]) slot = i;
        end
        for (i = 0; i < next_ptr && slot < 0; i++) begin
          if (!id_used[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        id_used[slot] = 1'b1;
        next_ptr = 9'(slot + 1);
        held_ids = held_ids + 9'd1;
        g.index = 8'(slot);
        g.ok = 1'b1;
      end else begin
        g.index = 8'(POOL - 1);
      end
    end else begin
      g.index = rel;
      if (rel < POOL && id_used[rel]) begin
        id_used[rel] = 1'b0;
        if (held_ids > 0) held_ids = held_ids - 9'd1;
        g.ok = 1'b1;
      end
    end
    g.count = held_ids;
    return g;
  endfunction

  task automatic report(input string what, input int got, input int want_v);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want_v);
    end
  endtask

  // one transfer per accepting edge on each side
  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (done !== 1'b0) begin
        if (pending_grants.size() == 0) begin
          report("result with nothing pending", granted_index, 0);
        end else begin
          want = pending_grants.pop_front();
          if (granted_index !== want.index) report("granted_index", granted_index, want.index);
          if (ok !== want.ok) report("ok", ok, want.ok);
          if (live_count !== want.count) report("live_count", live_count, want.count);
        end
      end
      if (start && !busy) begin
        want = compute_grant(op, release_index);
        if (row_typed) want = row_want;
        pending_grants.push_back(want);
        if (op == OP_ALLOC) begin
          if (want.ok) n_granted++;
          else n_refused++;
        end else begin
          if (want.ok) n_freed++;
          else n_bad_free++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_cmd(input logic cmd_op, input logic [7:0] cmd_index, input logic typed,
                          input grant_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start <= 1'b1;
    op <= cmd_op;
    release_index <= cmd_index;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained;
    start <= 1'b0;
    do @(negedge clk); while (pending_grants.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    int         n;
    int         k;
    int         mode;
    int         phase_left;
    int         alloc_pct;
    logic [7:0] pick;
    phase_left = 0;
    mode = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_cmd(directed_rows[n].op, directed_rows[n].index, directed_rows[n].typed,
               directed_rows[n].want);
    end
    wait_drained;

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        // fill the pool, hit it while full, then wrap from the end of the range
        while (held_ids != POOL) send_cmd(OP_ALLOC, 8'($urandom), 1'b0, '0);
        repeat (3) send_cmd(OP_ALLOC, 8'($urandom), 1'b0, '0);
        send_cmd(OP_FREE, 8'd255, 1'b0, '0);
        send_cmd(OP_ALLOC, 8'($urandom), 1'b0, '0);
        send_cmd(OP_FREE, 8'd7, 1'b0, '0);
        send_cmd(OP_ALLOC, 8'($urandom), 1'b0, '0);
        send_cmd(OP_ALLOC, 8'($urandom), 1'b0, '0);
        send_cmd(OP_FREE, 8'd0, 1'b0, '0);
        send_cmd(OP_FREE, 8'd255, 1'b0, '0);
        wait_drained;
      end
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      case (mode)
        0: alloc_pct = 25;
        2: alloc_pct = 85;
        default: alloc_pct = 50;
      endcase
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_cmd(OP_ALLOC, 8'($urandom), 1'b0, '0);
      end else begin
        pick = 8'($urandom);
        if (mode != 3 && $urandom_range(0, 4) != 0) begin
          for (k = 0; k < POOL; k++) begin
            if (id_used[8'(pick + k)]) begin
              pick = 8'(pick + k);
              break;
            end
          end
        end
        send_cmd(OP_FREE, pick, 1'b0, '0);
      end
    end

    wait_drained;
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("allocations: %0d granted, %0d refused on a full pool", n_granted, n_refused);
    $display("frees: %0d of held ids, %0d of free ids; %0d mismatches", n_freed, n_bad_free,
             errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
